// File: rtl/pulse_oximeter_spo2_and_pulse_macros.svh
`ifndef PULSE_OXIMETER_SPO2_AND_PULSE_MACROS_SVH
`define PULSE_OXIMETER_SPO2_AND_PULSE_MACROS_SVH

// Check a condition at every clock edge out of reset
`define POX_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle
`define POX_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pox_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pox_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // Configuration
  localparam int          SCALE_W     = 20;
  localparam logic [19:0] SCALE_RESET = 20'd30000;

  // Result fields and their places in the output tdata
  localparam int SPO2_W     = 7;
  localparam int PULSE_W    = 19;
  localparam int PERIOD_W   = 16;
  localparam int SPO2_LSB   = 0;
  localparam int PULSE_LSB  = SPO2_LSB + SPO2_W;
  localparam int PERIOD_LSB = PULSE_LSB + PULSE_W;
  localparam int OUT_DATA_W = ((PERIOD_LSB + PERIOD_W + 7) / 8) * 8;

  // Shared divider
  localparam int DVD_W  = 24;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] RATIO_STEPS = 5'd24;
  localparam logic [STEP_W-1:0] SPO2_STEPS  = 5'd7;
  localparam logic [STEP_W-1:0] PULSE_STEPS = 5'd20;

  // SpO2 curve in Q8.16 ratio units
  localparam logic [23:0] R_LOW     = 24'd26214;
  localparam logic [23:0] R_ONE     = 24'd65536;
  localparam logic [23:0] R_HIGH    = 24'd222822;
  localparam logic [23:0] LIN_BASE  = 24'd7208960;   // 110 in Q.16
  localparam logic [23:0] LIN_SLOPE = 24'd25;
  localparam logic [27:0] CUR_BASE  = 28'd94699520;  // 1445 in Q.16
  localparam logic [27:0] CUR_SLOPE = 28'd425;
  localparam logic [19:0] CUR_DIV   = 20'd786432;    // 12 in Q.16
  localparam logic [6:0]  SPO2_FULL = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_RATIO_CHK,
    ST_RATIO_WAIT,
    ST_MAP,
    ST_SPO2_WAIT,
    ST_PULSE_GO,
    ST_PULSE_WAIT,
    ST_FINISH
  } pox_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } pox_div_ctl_t;

endpackage
`default_nettype wire

// File: rtl/pox_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pox_div #(
  parameter int DIV_W = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pox_pkg::pox_div_ctl_t      ctl_i,
  input  wire logic [DIV_W-1:0]           rem0_i,
  input  wire logic [pox_pkg::DVD_W-1:0]  dvd_i,
  input  wire logic [DIV_W-1:0]           divisor_i,
  output logic                            done_o,
  output logic [pox_pkg::DVD_W-1:0]       quo_o
);
  import pox_pkg::*;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q;
  logic [DVD_W-1:0]  dvd_q, quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DIV_W:0]    trial;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
  end

  // Hold the step count and the finish pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      cnt_q  <= ctl_i.steps;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Advance remainder, dividend and quotient
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= rem0_i;
      dvd_q <= dvd_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: rtl/pulse_oximeter_spo2_and_pulse.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Handshake             Content
// s_axis     in   tvalid/tready         red_ac, ir_ac, red_dc, ir_dc
// m_axis     out  tvalid/tready         spo2_percent, pulse_bpm, period_samples; ratio_error
// cfg        in   cfg_we_i              pulse_scale
//
// A sample that does not end a period leaves the sequencer idle. After a period end, tready
// stays low for a wait set by the shared restoring divider: 24 steps for the ratio, 7 for the
// SpO2 curve and 20 for the pulse, plus the multiply states and sequencing. An error or a
// saturated ratio skips divisions. Reset is asynchronous and clears all statistics; there is
// no clearing pass. A result waits in the output register while further samples are taken; a
// second result then waits in the sequencer until the first is taken.
module pulse_oximeter_spo2_and_pulse #(
  parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = pox_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        cfg_we_i,
  input  wire logic [pox_pkg::SCALE_W-1:0]                 cfg_wdata_i,
  input  wire logic                                        s_axis_tvalid,
  output logic                                             s_axis_tready,
  // red_ac, ir_ac, red_dc, ir_dc, zero fill
  input  wire logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                             m_axis_tvalid,
  input  wire logic                                        m_axis_tready,
  // spo2_percent, pulse_bpm, period_samples, zero fill
  output logic [pox_pkg::OUT_DATA_W-1:0]                   m_axis_tdata,
  // ratio_error
  output logic                                             m_axis_tuser
);
  import pox_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int DIV_W = SAMPLE_BITS + 16;

  pox_state_e state_q, state_d;

  // Input fields
  logic signed [SB-1:0] red, ir;
  logic [15:0]          red_dc, ir_dc;
  assign red    = s_axis_tdata[SB-1:0];
  assign ir     = s_axis_tdata[2*SB-1:SB];
  assign red_dc = s_axis_tdata[2*SB+15:2*SB];
  assign ir_dc  = s_axis_tdata[2*SB+31:2*SB+16];

  // Running statistics
  logic signed [SB-1:0] prev_red_q, red_max_q, red_min_q, ir_max_q, ir_min_q;
  logic signed [SB-1:0] red_max_n, red_min_n, ir_max_n, ir_min_n;
  logic [CB-1:0]        count_q, count_n;
  logic [SCALE_W-1:0]   scale_q;
  logic                 accept, period_end;
  logic [SB:0]          red_ptp_w, ir_ptp_w;
  logic [31:0]          count_ext;

  // Latched period values and work registers
  logic [SB-1:0]       red_ptp_q, ir_ptp_q;
  logic [15:0]         red_dc_q, ir_dc_q;
  logic [CB-1:0]       cnt_lat_q;
  logic                err_q;
  logic [DIV_W-1:0]    prod_num_q, den_q, prod;
  logic [SB-1:0]       mul_a;
  logic [15:0]         mul_b;
  logic [23:0]         r_q;
  logic [SPO2_W-1:0]   spo2_q;
  logic [PULSE_W-1:0]  pulse_q;
  logic [23:0]         lin_w;
  logic [27:0]         cur_w;
  logic                ratio_ovf;

  // Output register
  logic                out_valid_q, out_err_q;
  logic [SPO2_W-1:0]   out_spo2_q;
  logic [PULSE_W-1:0]  out_pulse_q;
  logic [PERIOD_W-1:0] out_period_q;
  logic                out_load;

  // Divider hookup
  pox_div_ctl_t        div_ctl;
  logic [DIV_W-1:0]    div_rem0, div_divisor;
  logic [DVD_W-1:0]    div_dvd, div_quo;
  logic                div_done;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Fold the new sample into the statistics
  always_comb begin
    count_n   = (count_q == '1) ? count_q : count_q + 1'b1;
    red_max_n = (red > red_max_q) ? red : red_max_q;
    red_min_n = (red < red_min_q) ? red : red_min_q;
    ir_max_n  = (ir > ir_max_q) ? ir : ir_max_q;
    ir_min_n  = (ir < ir_min_q) ? ir : ir_min_q;
    red_ptp_w = {red_max_n[SB-1], red_max_n} - {red_min_n[SB-1], red_min_n};
    ir_ptp_w  = {ir_max_n[SB-1], ir_max_n} - {ir_min_n[SB-1], ir_min_n};
    period_end = !red[SB-1] && (red != '0) && prev_red_q[SB-1] && (count_n != CB'(1));
  end

  // Hold configuration and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= SCALE_RESET;
      prev_red_q <= '0;
      red_max_q  <= '0;
      red_min_q  <= '0;
      ir_max_q   <= '0;
      ir_min_q   <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (accept) begin
        prev_red_q <= red;
        if (period_end) begin
          red_max_q <= '0;
          red_min_q <= '0;
          ir_max_q  <= '0;
          ir_min_q  <= '0;
          count_q   <= '0;
        end else begin
          red_max_q <= red_max_n;
          red_min_q <= red_min_n;
          ir_max_q  <= ir_max_n;
          ir_min_q  <= ir_min_n;
          count_q   <= count_n;
        end
      end
    end
  end

  // Shared multiplier, one product per cycle
  always_comb begin
    mul_a = (state_q == ST_MUL_NUM) ? red_ptp_q : ir_ptp_q;
    mul_b = (state_q == ST_MUL_NUM) ? ir_dc_q : red_dc_q;
    prod  = DIV_W'(mul_a) * DIV_W'(mul_b);
  end

  // SpO2 curve pieces and the ratio overflow test
  always_comb begin
    lin_w     = LIN_BASE - (24'(r_q[15:0]) * LIN_SLOPE);
    cur_w     = CUR_BASE - (28'(r_q[17:0]) * CUR_SLOPE);
    ratio_ovf = DIV_W'(prod_num_q[DIV_W-1:8]) >= den_q;
  end

  // Sequencer: next state and divider requests
  always_comb begin
    state_d       = state_q;
    div_ctl.start = 1'b0;
    div_ctl.steps = RATIO_STEPS;
    div_rem0      = DIV_W'(prod_num_q[DIV_W-1:8]);
    div_dvd       = {prod_num_q[7:0], 16'h0000};
    div_divisor   = den_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && period_end) state_d = ST_MUL_NUM;
      end
      ST_MUL_NUM: state_d = ST_MUL_DEN;
      ST_MUL_DEN: state_d = err_q ? ST_PULSE_GO : ST_RATIO_CHK;
      ST_RATIO_CHK: begin
        if (ratio_ovf) begin
          state_d = ST_PULSE_GO;
        end else begin
          div_ctl.start = 1'b1;
          state_d       = ST_RATIO_WAIT;
        end
      end
      ST_RATIO_WAIT: begin
        if (div_done) state_d = ST_MAP;
      end
      ST_MAP: begin
        if (r_q >= R_ONE && r_q <= R_HIGH) begin
          div_ctl.start = 1'b1;
          div_ctl.steps = SPO2_STEPS;
          div_rem0      = DIV_W'(cur_w[27:7]);
          div_dvd       = {cur_w[6:0], 17'h0};
          div_divisor   = DIV_W'(CUR_DIV);
          state_d       = ST_SPO2_WAIT;
        end else begin
          state_d = ST_PULSE_GO;
        end
      end
      ST_SPO2_WAIT: begin
        if (div_done) state_d = ST_PULSE_GO;
      end
      ST_PULSE_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = PULSE_STEPS;
        div_rem0      = '0;
        div_dvd       = {scale_q, 4'h0};
        div_divisor   = DIV_W'(cnt_lat_q);
        state_d       = ST_PULSE_WAIT;
      end
      ST_PULSE_WAIT: begin
        if (div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Capture period values and divider results
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && period_end) begin
          red_ptp_q <= red_ptp_w[SB-1:0];
          ir_ptp_q  <= ir_ptp_w[SB-1:0];
          red_dc_q  <= red_dc;
          ir_dc_q   <= ir_dc;
          cnt_lat_q <= count_n;
          err_q     <= (red_dc == '0) || (ir_dc == '0) || (ir_ptp_w == '0);
          spo2_q    <= '0;
        end
      end
      ST_MUL_NUM:  prod_num_q <= prod;
      ST_MUL_DEN:  den_q      <= prod;
      ST_RATIO_WAIT: begin
        if (div_done) r_q <= div_quo;
      end
      ST_MAP: begin
        if (r_q <= R_LOW)      spo2_q <= SPO2_FULL;
        else if (r_q < R_ONE)  spo2_q <= lin_w[22:16];
        else                   spo2_q <= '0;
      end
      ST_SPO2_WAIT: begin
        if (div_done) spo2_q <= div_quo[SPO2_W-1:0];
      end
      ST_PULSE_WAIT: begin
        if (div_done) pulse_q <= div_quo[PULSE_W-1:0];
      end
      default: ;
    endcase
  end

  pox_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .rem0_i   (div_rem0),
    .dvd_i    (div_dvd),
    .divisor_i(div_divisor),
    .done_o   (div_done),
    .quo_o    (div_quo)
  );

  // Output register: hold the result until the transaction completes
  assign count_ext = 32'(cnt_lat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_spo2_q   <= spo2_q;
      out_pulse_q  <= pulse_q;
      out_period_q <= (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
      out_err_q    <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_period_q, out_pulse_q, out_spo2_q});

endmodule
`default_nettype wire

// File: rtl/pox_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_oximeter_spo2_and_pulse_macros.svh"
module pox_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pox_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import pox_pkg::*;

  logic [SPO2_W-1:0]   spo2;
  logic [PERIOD_W-1:0] period;
  assign spo2   = m_axis_tdata[PULSE_LSB-1:SPO2_LSB];
  assign period = m_axis_tdata[PERIOD_LSB+PERIOD_W-1:PERIOD_LSB];

  // A stalled result stays offered
  `POX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  // SpO2 never exceeds full saturation
  `POX_ASSERT(a_spo2_range, !m_axis_tvalid || spo2 <= SPO2_FULL, "spo2 above 100")
  // A ratio error always reports zero saturation
  `POX_ASSERT(a_err_zero, !m_axis_tvalid || !m_axis_tuser || spo2 == '0, "error with nonzero spo2")
  // A period holds at least two samples
  `POX_ASSERT(a_period_min, !m_axis_tvalid || period >= 16'd2, "period shorter than two samples")

endmodule

bind pulse_oximeter_spo2_and_pulse pox_checker u_pox_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
